[sv/irm_pkg.sv]
// ----------------------------------------------------------------------------
// irm_pkg - shared types and constants for the ICMP reply matcher
// Transaction structs, ICMP codes, register indexes and the small residue
// table used to fold sequence numbers onto probe slots.
// ----------------------------------------------------------------------------
`default_nettype none

package irm_pkg;

  localparam int PROBES_PER_ROUND = 3;
  localparam int SLOT_W = (PROBES_PER_ROUND > 1) ? $clog2(PROBES_PER_ROUND) : 1;

  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam int         ICMP_HEAD_BYTES    = 8;
  localparam int         WORD_BYTES         = 4;

  localparam logic [1:0] KIND_ECHO_REPLY    = 2'd0;
  localparam logic [1:0] KIND_TIME_EXCEEDED = 2'd1;
  localparam logic [1:0] KIND_OTHER         = 2'd2;

  localparam logic [1:0] CFG_BASE_SEQUENCE = 2'd0;
  localparam logic [1:0] CFG_OWN_ID        = 2'd1;
  localparam logic [1:0] CFG_DEST_ADDRESS  = 2'd2;

  // weight of each nibble of a 16-bit value modulo the probe count
  localparam int NIB_W0 = 1 % PROBES_PER_ROUND;
  localparam int NIB_W1 = 16 % PROBES_PER_ROUND;
  localparam int NIB_W2 = 256 % PROBES_PER_ROUND;
  localparam int NIB_W3 = 4096 % PROBES_PER_ROUND;

  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic        last;
    logic [2:0]  probe_offset;
    logic [31:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic [1:0]  reply_kind;
    logic [2:0]  slot;
    logic [31:0] round_trip_us;
    logic [31:0] source_address;
    logic        reached_destination;
  } out_item_t;

  // packet verdict, meaningful on the last byte
  typedef struct packed {
    logic              matched;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       source;
    logic              reached;
  } parse_res_t;

  // residue of a small value modulo the probe count (constant table)
  function automatic logic [2:0] mod_small(input logic [6:0] x);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 128; i++) begin
      if (x == 7'(i)) r = 3'(i % PROBES_PER_ROUND);
    end
    return r;
  endfunction

  // 16-bit value modulo the probe count by nibble weights
  function automatic logic [2:0] mod_word(input logic [15:0] x);
    logic [6:0] sum;
    sum = 7'(mod_small(7'(x[3:0] * 7'(NIB_W0))))
        + 7'(mod_small(7'(x[7:4] * 7'(NIB_W1))))
        + 7'(mod_small(7'(x[11:8] * 7'(NIB_W2))))
        + 7'(mod_small(7'(x[15:12] * 7'(NIB_W3))));
    return mod_small(sum);
  endfunction

endpackage

`default_nettype wire

[sv/irm_ram.sv]
// ----------------------------------------------------------------------------
// irm_ram - generic single-port-write, registered-read RAM
// One write and one read per cycle; read returns the old entry on a
// same-address collision.
// ----------------------------------------------------------------------------
`default_nettype none

module irm_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/irm_parser.sv]
// ----------------------------------------------------------------------------
// irm_parser - byte-serial IPv4/ICMP header parser
// Tracks byte position, header lengths, type, id and sequence; gives the
// match verdict for the byte in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module irm_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                last,
  input  logic [15:0]         base_sequence,
  input  logic [2:0]          base_mod,
  input  logic [15:0]         own_id,
  input  logic [31:0]         dest_address,
  output irm_pkg::parse_res_t res
);

  import irm_pkg::*;

  logic [15:0] byte_position;
  logic [3:0]  outer_header_words;
  logic [3:0]  inner_header_words;
  logic [7:0]  message_type;
  logic [15:0] reply_id;
  logic [15:0] reply_sequence;
  logic [31:0] source_capture;

  logic [3:0]  ohw_e, ihw_e;
  logic [7:0]  mt_e;
  logic [15:0] id_e, seq_e;
  logic [31:0] src_e;
  logic [7:0]  o8, o_head, inner8, start8;
  logic        is_echo, is_tx, take_ids, complete;
  logic [16:0] seq_diff;
  logic        in_range;

  always_comb begin
    ohw_e  = (byte_position == 16'd0) ? data_byte[3:0] : outer_header_words;
    o8     = {2'b00, ohw_e, 2'b00};
    o_head = o8 + 8'(ICMP_HEAD_BYTES);

    src_e = source_capture;
    if (byte_position >= 16'd12 && byte_position <= 16'd15) begin
      case (byte_position[1:0])
        2'd0:    src_e[31:24] = data_byte;
        2'd1:    src_e[23:16] = data_byte;
        2'd2:    src_e[15:8]  = data_byte;
        default: src_e[7:0]   = data_byte;
      endcase
    end

    mt_e    = (byte_position == {8'd0, o8}) ? data_byte : message_type;
    is_echo = (mt_e == TYPE_ECHO_REPLY);
    is_tx   = (mt_e == TYPE_TIME_EXCEEDED);

    ihw_e  = (is_tx && byte_position == {8'd0, o_head}) ? data_byte[3:0]
                                                        : inner_header_words;
    inner8 = o_head + {2'b00, ihw_e, 2'b00};

    start8   = is_echo ? o8 : inner8;
    take_ids = is_echo || (is_tx && byte_position > {8'd0, o_head});
    id_e     = reply_id;
    seq_e    = reply_sequence;
    if (take_ids) begin
      if (byte_position == {8'd0, start8 + 8'd4}) id_e[7:0]   = data_byte;
      if (byte_position == {8'd0, start8 + 8'd5}) id_e[15:8]  = data_byte;
      if (byte_position == {8'd0, start8 + 8'd6}) seq_e[7:0]  = data_byte;
      if (byte_position == {8'd0, start8 + 8'd7}) seq_e[15:8] = data_byte;
    end

    complete = 1'b0;
    res.kind = KIND_OTHER;
    if (byte_position >= {8'd0, o8} && byte_position >= 16'd15) begin
      if (is_echo && byte_position >= {8'd0, o8 + 8'd7}) begin
        complete = 1'b1;
        res.kind = KIND_ECHO_REPLY;
      end else if (is_tx && byte_position >= {8'd0, o_head} &&
                   byte_position >= {8'd0, inner8 + 8'd7}) begin
        complete = 1'b1;
        res.kind = KIND_TIME_EXCEEDED;
      end
    end

    // borrow-free difference below the probe count means in range
    seq_diff    = {1'b0, seq_e} - {1'b0, base_sequence};
    in_range    = !seq_diff[16] && (seq_diff < 17'(PROBES_PER_ROUND));
    res.matched = complete && (id_e == own_id) && in_range;
    res.slot    = SLOT_W'(mod_small(7'(base_mod) + 7'(seq_diff[2:0])));
    res.source  = src_e;
    res.reached = res.matched && (src_e == dest_address);
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      byte_position      <= '0;
      outer_header_words <= '0;
      inner_header_words <= '0;
      message_type       <= '0;
      reply_id           <= '0;
      reply_sequence     <= '0;
      source_capture     <= '0;
    end else if (take) begin
      if (byte_position != 16'hFFFF) begin
        byte_position <= byte_position + 16'd1;
      end
      outer_header_words <= ohw_e;
      inner_header_words <= ihw_e;
      message_type       <= mt_e;
      reply_id           <= id_e;
      reply_sequence     <= seq_e;
      source_capture     <= src_e;
    end
  end

endmodule

`default_nettype wire

[sv/icmp_reply_matcher.sv]
// ----------------------------------------------------------------------------
// icmp_reply_matcher - match ICMP echo / time-exceeded replies to probes
// Stores probe send times in a small stamp RAM, parses received packets a
// byte at a time and reports round-trip time for replies of this round.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake           transaction
//  --------  ----  ------------------  --------------------------------------
//  in        in    in_valid/in_ready   send stamp or one packet byte
//  out       out   out_valid/out_ready one verdict per last packet byte
//  cfg       in    cfg_write           register write, no wait, no read-back
//
//  One input transaction per cycle, except while stalled as below; a verdict
//  passes from the stage-two registers into the output register (stamp RAM
//  read at the accepting edge, subtract in the second stage).
//  The stamp RAM has one write port, shared by send stamps and round-trip
//  write-back, both issued from the second stage in arrival order.
//  Reset clears the stamps through per-slot valid bits: no clearing pass.
//  Input stalls only while a verdict waits in stage two behind a full,
//  unaccepted output register.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_reply_matcher (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  irm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output irm_pkg::out_item_t out_item,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  import irm_pkg::*;

  // configuration
  logic [15:0] base_sequence;
  logic [15:0] own_id;
  logic [31:0] dest_address;
  logic [2:0]  base_mod;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_sequence <= '0;
      own_id        <= '0;
      dest_address  <= '0;
      base_mod      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BASE_SEQUENCE: begin
          base_sequence <= cfg_data[15:0];
          base_mod      <= mod_word(cfg_data[15:0]);
        end
        CFG_OWN_ID:       own_id       <= cfg_data[15:0];
        CFG_DEST_ADDRESS: dest_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: accept, parse, issue stamp read
  logic       advance, accept, take_byte;
  parse_res_t res;

  logic              s1_valid, s1_result, s1_matched, s1_reached;
  logic [1:0]        s1_kind;
  logic [SLOT_W-1:0] s1_addr;
  logic [31:0]       s1_time, s1_source;

  // advance unless a verdict in stage two is blocked by the output
  assign advance   = !(s1_valid && s1_result) || !out_valid || out_ready;
  assign in_ready  = advance;
  assign accept    = in_valid && advance;
  assign take_byte = accept && in_item.mode;

  irm_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .take          (take_byte),
    .data_byte     (in_item.data_byte),
    .last          (in_item.last),
    .base_sequence (base_sequence),
    .base_mod      (base_mod),
    .own_id        (own_id),
    .dest_address  (dest_address),
    .res           (res)
  );

  logic [SLOT_W-1:0] stamp_slot;
  assign stamp_slot = SLOT_W'(mod_small(7'(base_mod) + 7'(in_item.probe_offset)));

  // stage 1 write port: stamp store or round-trip write-back
  logic        s1_we;
  logic [31:0] s1_wdata, rtt, stamp_val, ram_rdata, fwd_data;
  logic        fwd_hit, rd_valid;
  logic [PROBES_PER_ROUND-1:0] stamp_valid;

  assign s1_we    = s1_valid && advance && (!s1_result || s1_matched);
  assign stamp_val = fwd_hit ? fwd_data : (rd_valid ? ram_rdata : 32'd0);
  assign rtt      = s1_time - stamp_val;
  assign s1_wdata = s1_result ? rtt : s1_time;

  irm_ram #(
    .WIDTH (32),
    .DEPTH (PROBES_PER_ROUND)
  ) u_stamps (
    .clk   (clk),
    .we    (s1_we),
    .waddr (s1_addr),
    .wdata (s1_wdata),
    .re    (advance),
    .raddr (res.slot),
    .rdata (ram_rdata)
  );

  // forward a same-cycle write to the slot being read; hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (advance) begin
      fwd_hit <= s1_we && (s1_addr == res.slot);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_data <= s1_wdata;
      rd_valid <= stamp_valid[res.slot];
    end
  end

  // valid bits stand in for the zero reset of the stamp RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_valid <= '0;
    end else if (s1_we) begin
      stamp_valid[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && (!in_item.mode || in_item.last);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_result  <= in_item.mode;
      s1_addr    <= in_item.mode ? res.slot : stamp_slot;
      s1_time    <= in_item.time_now;
      s1_matched <= res.matched;
      s1_kind    <= res.kind;
      s1_source  <= res.source;
      s1_reached <= res.reached;
    end
  end

  // output register: load a verdict, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_result && advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_result && advance) begin
      out_item.matched             <= s1_matched;
      out_item.reply_kind          <= s1_kind;
      out_item.slot                <= s1_matched ? 3'(s1_addr) : 3'd0;
      out_item.round_trip_us       <= s1_matched ? rtt : 32'd0;
      out_item.source_address      <= s1_source;
      out_item.reached_destination <= s1_reached;
    end
  end

  // a verdict held in stage two behind a blocked output must stall input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_result && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while verdict blocked");

  a_reach: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.reached_destination) |-> out_item.matched)
    else $error("destination flag without match");

  a_unmatched: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.matched) |->
      (out_item.round_trip_us == 32'd0 && out_item.slot == 3'd0))
    else $error("unmatched verdict carries slot or time");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.matched) |->
      (out_item.reply_kind != KIND_OTHER &&
       out_item.slot < 3'(PROBES_PER_ROUND)))
    else $error("matched verdict with bad kind or slot");

endmodule

`default_nettype wire

[dv/irm_reply_checker.sv]
// ----------------------------------------------------------------------------
// irm_reply_checker - verdict predictor and comparator for icmp_reply_matcher
// Watches the input, output and register channels, mirrors the packet parse
// and the stamp store, and compares every verdict with the oldest one due.
// ----------------------------------------------------------------------------
module irm_reply_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  irm_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  irm_pkg::out_item_t out_item,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 mismatch_count,
  output int                 verdicts_pending,
  output int                 verdicts_seen,
  output int                 matches_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import irm_pkg::*;

  logic [15:0] base_seq;
  logic [15:0] probe_id;
  logic [31:0] dest_addr;

  logic [15:0] rx_pos;
  logic [3:0]  outer_ihl;
  logic [3:0]  inner_ihl;
  logic [7:0]  rx_type;
  logic [15:0] rx_id;
  logic [15:0] rx_seq;
  logic [31:0] rx_source;
  logic [31:0] stamp_mem [PROBES_PER_ROUND];

  out_item_t verdicts_due [$];

  function automatic void clear_parse();
    rx_pos    = '0;
    outer_ihl = '0;
    inner_ihl = '0;
    rx_type   = '0;
    rx_id     = '0;
    rx_seq    = '0;
    rx_source = '0;
  endfunction

  // id and sequence sit at start+4..start+7, low byte first
  function automatic void take_id_seq(input int p, input int start, input logic [7:0] b);
    if (p == start + 4) rx_id[7:0]   = b;
    if (p == start + 5) rx_id[15:8]  = b;
    if (p == start + 6) rx_seq[7:0]  = b;
    if (p == start + 7) rx_seq[15:8] = b;
  endfunction

  function automatic string show(input out_item_t v);
    return $sformatf("m=%0d kind=%0d slot=%0d rtt=%h src=%h reached=%0d", v.matched,
                     v.reply_kind, v.slot, v.round_trip_us, v.source_address,
                     v.reached_destination);
  endfunction

  // Advance the mirrored parse by one transaction; queue a verdict on a last byte.
  function automatic void absorb_item(input in_item_t it);
    int         p;
    int         o;
    int         inner;
    int         slot_idx;
    logic       complete;
    logic       hit;
    logic [1:0] kind;
    logic [31:0] rtt;
    out_item_t  v;
    if (!it.mode) begin
      stamp_mem[(int'(base_seq) + int'(it.probe_offset)) % PROBES_PER_ROUND] = it.time_now;
      return;
    end
    p = int'(rx_pos);
    if (p == 0) outer_ihl = it.data_byte[3:0];
    o = WORD_BYTES * int'(outer_ihl);
    if (p >= 12 && p <= 15) rx_source[8 * (15 - p) +: 8] = it.data_byte;
    if (p == o) rx_type = it.data_byte;
    if (rx_type == TYPE_ECHO_REPLY) take_id_seq(p, o, it.data_byte);
    if (rx_type == TYPE_TIME_EXCEEDED && p == o + ICMP_HEAD_BYTES)
      inner_ihl = it.data_byte[3:0];
    inner = o + ICMP_HEAD_BYTES + WORD_BYTES * int'(inner_ihl);
    if (rx_type == TYPE_TIME_EXCEEDED && p > o + ICMP_HEAD_BYTES)
      take_id_seq(p, inner, it.data_byte);

    if (!it.last) begin
      if (rx_pos != 16'hFFFF) rx_pos = rx_pos + 16'd1;
      return;
    end

    complete = 1'b0;
    kind     = KIND_OTHER;
    if (p >= o && p >= 15) begin
      if (rx_type == TYPE_ECHO_REPLY && p >= o + 7) begin
        complete = 1'b1;
        kind     = KIND_ECHO_REPLY;
      end else if (rx_type == TYPE_TIME_EXCEEDED && p >= o + ICMP_HEAD_BYTES &&
                   p >= inner + 7) begin
        complete = 1'b1;
        kind     = KIND_TIME_EXCEEDED;
      end
    end
    hit = complete && rx_id == probe_id && rx_seq >= base_seq &&
          int'(rx_seq) < int'(base_seq) + PROBES_PER_ROUND;

    v = '0;
    v.reply_kind     = kind;
    v.source_address = rx_source;
    if (hit) begin
      slot_idx = int'(rx_seq) % PROBES_PER_ROUND;
      rtt = it.time_now - stamp_mem[slot_idx];
      stamp_mem[slot_idx] = rtt;
      v.matched             = 1'b1;
      v.slot                = 3'(slot_idx);
      v.round_trip_us       = rtt;
      v.reached_destination = (rx_source == dest_addr);
    end
    verdicts_due.push_back(v);
    clear_parse();
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      base_seq  = '0;
      probe_id  = '0;
      dest_addr = '0;
      clear_parse();
      for (int i = 0; i < PROBES_PER_ROUND; i++) stamp_mem[i] = '0;
      verdicts_due.delete();
      mismatch_count = 0;
      verdicts_seen  = 0;
      matches_seen   = 0;
    end else begin
      // compare first, so a verdict can never be paired with this edge's input
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (out_item.matched === 1'b1) matches_seen++;
        if (verdicts_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected verdict: %s", $realtime, show(out_item));
          mismatch_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_item.matched !== want.matched ||
              out_item.reply_kind !== want.reply_kind ||
              out_item.slot !== want.slot ||
              out_item.round_trip_us !== want.round_trip_us ||
              out_item.source_address !== want.source_address ||
              out_item.reached_destination !== want.reached_destination) begin
            if (mismatch_count < 10)
              $display("%0t: verdict mismatch\n  expected %s\n  actual   %s",
                       $realtime, show(want), show(out_item));
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) absorb_item(in_item);
      if (cfg_write) begin
        case (cfg_index)
          CFG_BASE_SEQUENCE: base_seq  = cfg_data[15:0];
          CFG_OWN_ID:        probe_id  = cfg_data[15:0];
          CFG_DEST_ADDRESS:  dest_addr = cfg_data;
          default: ;
        endcase
      end
    end
    verdicts_pending = verdicts_due.size();
  end

endmodule

[dv/icmp_reply_matcher_tb.sv]
// ----------------------------------------------------------------------------
// icmp_reply_matcher_tb - stimulus and verdict for the ICMP reply matcher
// Sends send stamps and byte streams of echo replies, time-exceeded
// messages, foreign and truncated packets under several register settings,
// with random gaps and output stalls; irm_reply_checker does the checking.
// ----------------------------------------------------------------------------
module icmp_reply_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irm_pkg::*;

  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 120;
  localparam int PHASE_PACKETS = 3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int mismatch_count;
  int verdicts_pending;
  int verdicts_seen;
  int matches_seen;

  // stimulus bookkeeping
  logic [15:0] cur_base;
  logic [15:0] cur_id;
  logic [31:0] cur_dest;
  logic [31:0] now_us;
  logic [7:0]  pkt [$];
  bit          sender_eager;
  bit          reader_eager;
  int          items_sent;
  int          byte_items;
  int          stamps_sent;
  int          packets_sent;
  int          settings_used;

  icmp_reply_matcher DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  irm_reply_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .verdicts_pending (verdicts_pending),
    .verdicts_seen    (verdicts_seen),
    .matches_seen     (matches_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("icmp_reply_matcher_tb: done, errors");
    $finish;
  end

  // Output side: ready bursts broken by stalls, mostly short and a few long.
  // Each iteration owns its own falling edge, so ready never gets two updates
  // in one step.
  initial begin
    int n;
    int r;
    out_ready = 1'b0;
    forever begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      if (!reader_eager) begin
        r = $urandom_range(0, 99);
        n = (r < 70) ? $urandom_range(1, 2) : (r < 95) ? $urandom_range(3, 8) :
            $urandom_range(20, 40);
        repeat (n) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
    end
  end

  // Advance the microsecond clock: small steps, now and then a jump anywhere.
  function automatic logic [31:0] next_time();
    if ($urandom_range(0, 63) == 0) now_us = $urandom;
    else now_us = now_us + 32'($urandom_range(1, 40));
    return now_us;
  endfunction

  function automatic int pick_gap();
    int r;
    if (sender_eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // Offer one transaction after an optional gap; hold it until accepted.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_stamp(input logic [2:0] offset, input logic [31:0] stamp_time);
    in_item_t it;
    it.mode         = 1'b0;
    it.data_byte    = 8'($urandom);
    it.last         = 1'($urandom);
    it.probe_offset = offset;
    it.time_now     = stamp_time;
    send_item(it);
    stamps_sent++;
  endtask

  // Stream the packet buffer; mix_pct percent of bytes get a send stamp
  // slipped in ahead of them.
  task automatic send_packet(input int mix_pct);
    in_item_t it;
    for (int i = 0; i < pkt.size(); i++) begin
      if ($urandom_range(0, 99) < mix_pct) send_stamp(3'($urandom), next_time());
      it.mode         = 1'b1;
      it.data_byte    = pkt[i];
      it.last         = (i == pkt.size() - 1);
      it.probe_offset = 3'($urandom);
      it.time_now     = next_time();
      send_item(it);
      byte_items++;
    end
    packets_sent++;
  endtask

  // Fill the packet buffer with random bytes, then lay the header fields over
  // them. Overlapping fields (short headers) are written in order, last wins.
  function automatic void build_reply(input logic [3:0] ihl, input logic [7:0] msg_type,
                                      input logic [3:0] inner_ihl, input logic [15:0] id,
                                      input logic [15:0] seq, input logic [31:0] src);
    int o;
    int idp;
    int len;
    o   = WORD_BYTES * int'(ihl);
    idp = (msg_type == TYPE_TIME_EXCEEDED) ?
          o + ICMP_HEAD_BYTES + WORD_BYTES * int'(inner_ihl) : o;
    len = ((idp + 8 > 16) ? idp + 8 : 16) + $urandom_range(0, 6);
    pkt.delete();
    repeat (len) pkt.push_back(8'($urandom));
    pkt[0] = {4'($urandom), ihl};
    for (int k = 0; k < 4; k++) pkt[12 + k] = src[8 * (3 - k) +: 8];
    pkt[o] = msg_type;
    if (msg_type == TYPE_TIME_EXCEEDED) pkt[o + ICMP_HEAD_BYTES] = {4'($urandom), inner_ihl};
    pkt[idp + 4] = id[7:0];
    pkt[idp + 5] = id[15:8];
    pkt[idp + 6] = seq[7:0];
    pkt[idp + 7] = seq[15:8];
  endfunction

  function automatic void cut_packet(input int keep);
    while (pkt.size() > keep) void'(pkt.pop_back());
  endfunction

  // Drop valid and wait until every verdict is back, then let the stamp
  // write-back stage drain before anything touches the registers.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input logic [15:0] base, input logic [15:0] id,
                            input logic [31:0] dest);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_BASE_SEQUENCE;
    cfg_data  <= {16'h0000, base};
    @(negedge clk);
    cfg_index <= CFG_OWN_ID;
    cfg_data  <= {16'h0000, id};
    @(negedge clk);
    cfg_index <= CFG_DEST_ADDRESS;
    cfg_data  <= dest;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_base = base;
    cur_id   = id;
    cur_dest = dest;
    settings_used++;
  endtask

  // One random packet: mostly well-formed replies aimed at this round,
  // the rest foreign types, wrong ids or sequences, and truncations.
  task automatic random_packet();
    int          r;
    logic [3:0]  ihl;
    logic [3:0]  iihl;
    logic [7:0]  ty;
    logic [15:0] id;
    logic [15:0] seq;
    logic [31:0] src;
    r = $urandom_range(0, 99);
    ihl  = ($urandom_range(0, 99) < 80) ? 4'd5 :
           ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(6, 15));
    iihl = ($urandom_range(0, 99) < 80) ? 4'd5 : 4'($urandom);
    if (r < 40 || r >= 88) ty = (r % 2 == 0) ? TYPE_ECHO_REPLY : TYPE_TIME_EXCEEDED;
    else if (r < 75) ty = TYPE_TIME_EXCEEDED;
    else begin
      do ty = 8'($urandom); while (ty == TYPE_ECHO_REPLY || ty == TYPE_TIME_EXCEEDED);
    end
    id  = ($urandom_range(0, 9) < 8) ? cur_id : 16'($urandom);
    seq = ($urandom_range(0, 9) < 8) ? cur_base + 16'($urandom_range(0, PROBES_PER_ROUND - 1))
                                     : cur_base + 16'($urandom_range(0, 8)) - 16'd3;
    src = $urandom_range(0, 1) ? cur_dest : $urandom;
    build_reply(ihl, ty, iihl, id, seq, src);
    if (r >= 88) cut_packet($urandom_range(1, pkt.size() - 1));
    send_packet(8);
  endtask

  // Stamp every probe of the round, plus a couple of stray offsets.
  task automatic stamp_round();
    for (int k = 0; k < PROBES_PER_ROUND; k++) send_stamp(3'(k), next_time());
    repeat (2) send_stamp(3'($urandom), next_time());
  endtask

  // Directed cases under the reset register values (base 0, id 0, dest 0).
  task automatic directed_cases();
    // time extremes; offset 7 folds onto the same slot as offset 1
    send_stamp(3'd0, 32'hFFFF_FFFF);
    send_stamp(3'd1, 32'h0000_0000);
    send_stamp(3'd2, next_time());
    send_stamp(3'd7, next_time());
    // echo reply matching slot 0, stamp wraps; source equals destination
    build_reply(4'd5, TYPE_ECHO_REPLY, 4'd0, 16'h0000, 16'd0, 32'h0000_0000);
    send_packet(0);
    // time exceeded matching the top slot, source all ones
    build_reply(4'd5, TYPE_TIME_EXCEEDED, 4'd5, 16'h0000, 16'd2, 32'hFFFF_FFFF);
    send_packet(0);
    // second reply to slot 0 reads back the written round-trip time
    build_reply(4'd5, TYPE_ECHO_REPLY, 4'd0, 16'h0000, 16'd0, 32'h0000_0000);
    send_packet(0);
    // sequence just past the round, and a foreign identifier
    build_reply(4'd5, TYPE_ECHO_REPLY, 4'd0, 16'h0000, 16'd3, $urandom);
    send_packet(0);
    build_reply(4'd5, TYPE_ECHO_REPLY, 4'd0, 16'hFFFF, 16'd1, $urandom);
    send_packet(0);
    // some other ICMP type
    build_reply(4'd5, 8'd3, 4'd0, 16'h0000, 16'd1, $urandom);
    send_packet(0);
    // truncations: single byte, before byte 15, at the type, before inner id
    build_reply(4'd5, TYPE_ECHO_REPLY, 4'd0, 16'h0000, 16'd1, $urandom);
    cut_packet(1);
    send_packet(0);
    build_reply(4'd5, TYPE_ECHO_REPLY, 4'd0, 16'h0000, 16'd1, $urandom);
    cut_packet(10);
    send_packet(0);
    build_reply(4'd5, TYPE_TIME_EXCEEDED, 4'd5, 16'h0000, 16'd1, $urandom);
    cut_packet(21);
    send_packet(0);
    build_reply(4'd5, TYPE_TIME_EXCEEDED, 4'd5, 16'h0000, 16'd1, $urandom);
    cut_packet(50);
    send_packet(0);
    // short outer headers: fields share bytes
    build_reply(4'd0, TYPE_ECHO_REPLY, 4'd0, 16'h0000, 16'd1, $urandom);
    send_packet(0);
    build_reply(4'd2, TYPE_ECHO_REPLY, 4'd0, 16'h0000, 16'd1, $urandom);
    send_packet(0);
    // longest outer header, and a quoted header of zero length
    build_reply(4'd15, TYPE_ECHO_REPLY, 4'd0, 16'h0000, 16'd2, 32'h0000_0000);
    send_packet(0);
    build_reply(4'd5, TYPE_TIME_EXCEEDED, 4'd0, 16'h0000, 16'd1, 32'h0000_0000);
    send_packet(0);
    // stamps slipped between packet bytes must not disturb the parse
    build_reply(4'd5, TYPE_TIME_EXCEEDED, 4'd5, 16'h0000, 16'd0, 32'h0000_0000);
    send_packet(30);
  endtask

  initial begin
    int phase_start;
    int phase_packets;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_write    = 1'b0;
    cfg_index    = CFG_BASE_SEQUENCE;
    cfg_data     = '0;
    sender_eager = 1'b0;
    reader_eager = 1'b0;
    cur_base     = '0;
    cur_id       = '0;
    cur_dest     = '0;
    now_us       = $urandom;
    items_sent   = 0;
    byte_items   = 0;
    stamps_sent  = 0;
    packets_sent = 0;
    settings_used = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_cases();

    for (int ph = 1; ph <= PHASES; ph++) begin
      drain();
      case (ph)
        1:       write_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        2:       write_regs(16'hFFFE, 16'($urandom), $urandom);
        3:       write_regs(16'h0000, 16'hFFFF, 32'h0000_0000);
        4:       write_regs(16'hFFFD, 16'h0000, 32'hFFFF_FFFF);
        default: write_regs(16'($urandom), 16'($urandom), $urandom);
      endcase
      // some phases run with no idling on one side or the other
      sender_eager = ($urandom_range(0, 3) == 0);
      reader_eager = ($urandom_range(0, 3) == 0);
      stamp_round();
      phase_start   = items_sent;
      phase_packets = 0;
      while (items_sent - phase_start < PHASE_ITEMS || phase_packets < PHASE_PACKETS) begin
        if ($urandom_range(0, 5) == 0) stamp_round();
        random_packet();
        phase_packets++;
        // hold the sender until the matcher has nothing left in flight
        if ($urandom_range(0, 9) == 0) drain();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && verdicts_pending != 0; w++) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("icmp_reply_matcher_tb: %0d packets in %0d bytes, %0d send stamps, %0d settings",
             packets_sent, byte_items, stamps_sent, settings_used);
    $display("icmp_reply_matcher_tb: %0d verdicts compared, %0d of them matches",
             verdicts_seen, matches_seen);
    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("icmp_reply_matcher_tb: done, clean");
    end else begin
      $display("icmp_reply_matcher_tb: done, errors");
    end
    $finish;
  end

endmodule
